[rtl/amo_pkg.sv]
// Shared types, codes and constants of the atomic memory operation unit.
package amo_pkg;

  localparam int DEFAULT_STORE_WORDS = 1024;
  localparam int IDX_W = 10;
  localparam int IDX_MAX = 1023;

  localparam logic CMD_RMW = 1'b0;
  localparam logic CMD_CAS = 1'b1;

  localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] SIGN32 = 64'h0000_0000_8000_0000;
  localparam logic [63:0] INF64 = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] INF32 = 64'h0000_0000_7F80_0000;
  localparam logic [63:0] QNAN64 = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] QNAN32 = 64'h0000_0000_7FC0_0000;
  localparam logic [63:0] MASK32 = 64'h0000_0000_FFFF_FFFF;

  typedef enum logic [3:0] {
    K_XCHG, K_XCHGF, K_ADD, K_FADD, K_SUB, K_AND, K_OR, K_XOR,
    K_SMIN, K_SMAX, K_UMIN, K_UMAX, K_FMINIMUM, K_FMAXIMUM, K_FMINNUM, K_FMAXNUM
  } op_kind_e;

  typedef struct packed {
    logic     cmd;
    op_kind_e kind;
    logic     wide;
  } amo_op_t;

endpackage

[rtl/amo_store.sv]
// Word store with two registered read ports and one write port.
module amo_store #(
  parameter int WORDS = amo_pkg::DEFAULT_STORE_WORDS,
  parameter int AW = $clog2(WORDS)
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_a_i,
  input  logic [AW-1:0] rd_addr_b_i,
  output logic [31:0]   rd_data_a_o,
  output logic [31:0]   rd_data_b_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [31:0]   wr_data_i
);

  logic [31:0] mem [WORDS];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_a_o <= mem[rd_addr_a_i];
      rd_data_b_o <= mem[rd_addr_b_i];
    end
  end

endmodule

[rtl/amo_alu.sv]
// Exchange, integer, bitwise, min/max, float min/max and compare-exchange update logic.
module amo_alu (
  input  amo_pkg::amo_op_t op_i,
  input  logic [63:0]      old_i,
  input  logic [63:0]      operand_i,
  input  logic [63:0]      expected_i,
  output logic [63:0]      new_o
);
  import amo_pkg::*;

  logic [63:0] mask, sign, inf, qnan, res, ka, kb;
  logic        an, bn, fp_nan_prop, want_max;

  always_comb begin
    mask = op_i.wide ? '1 : MASK32;
    sign = op_i.wide ? SIGN64 : SIGN32;
    inf = op_i.wide ? INF64 : INF32;
    qnan = op_i.wide ? QNAN64 : QNAN32;
    an = (old_i & ~sign & mask) > inf;
    bn = (operand_i & ~sign & mask) > inf;
    ka = ((old_i & sign) != 64'd0) ? (~old_i & mask) : (old_i | sign);
    kb = ((operand_i & sign) != 64'd0) ? (~operand_i & mask) : (operand_i | sign);
    fp_nan_prop = (op_i.kind == K_FMINIMUM) || (op_i.kind == K_FMAXIMUM);
    want_max = (op_i.kind == K_FMAXIMUM) || (op_i.kind == K_FMAXNUM);
    unique case (op_i.kind)
      K_XCHG, K_XCHGF, K_FADD: res = operand_i;
      K_ADD: res = old_i + operand_i;
      K_SUB: res = old_i - operand_i;
      K_AND: res = old_i & operand_i;
      K_OR: res = old_i | operand_i;
      K_XOR: res = old_i ^ operand_i;
      K_SMIN: res = ((old_i ^ sign) < (operand_i ^ sign)) ? old_i : operand_i;
      K_SMAX: res = ((old_i ^ sign) > (operand_i ^ sign)) ? old_i : operand_i;
      K_UMIN: res = (old_i < operand_i) ? old_i : operand_i;
      K_UMAX: res = (old_i > operand_i) ? old_i : operand_i;
      default: begin
        if (fp_nan_prop && (an || bn)) begin
          res = qnan;
        end else if (an && bn) begin
          res = qnan;
        end else if (an) begin
          res = operand_i;
        end else if (bn) begin
          res = old_i;
        end else if (want_max) begin
          res = (ka > kb) ? old_i : operand_i;
        end else begin
          res = (ka < kb) ? old_i : operand_i;
        end
      end
    endcase
    if (op_i.cmd == CMD_CAS) begin
      new_o = (old_i == expected_i) ? operand_i : old_i;
    end else begin
      new_o = res & mask;
    end
  end

endmodule

[rtl/amo_fadd.sv]
// Multi-cycle IEEE binary32/binary64 adder with round to nearest even.
module amo_fadd (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        wide_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] result_o
);
  import amo_pkg::*;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_ALIGN = 3'd1;
  localparam logic [2:0] F_NORM = 3'd2;
  localparam logic [2:0] F_ROUND = 3'd3;
  localparam logic [2:0] F_DONE = 3'd4;

  logic [2:0]  state_q, state_d;
  logic        wide_q, sa_q, sub_q, sign_q;
  logic [11:0] ea_q, eb_q, e_q;
  logic [52:0] ma_q, mb_q;
  logic [56:0] s_q;
  logic [63:0] result_q;

  logic        a_sign, b_sign, a_nan, b_nan, a_inf, b_inf, a_ge;
  logic [11:0] a_exp, b_exp, a_eeff, b_eeff, emax;
  logic [52:0] a_sig, b_sig;
  logic [62:0] a_mag, b_mag;
  logic [63:0] qnan, a_in, b_in, spec_res;
  logic        special;

  logic [11:0] d;
  logic [55:0] bw, shv, lost;
  logic        st;
  logic [56:0] sum;

  logic [53:0] mant, mr;
  logic        g, rst_bit, up, ovf, hidden;
  logic [11:0] er, ef;
  logic [63:0] rnd_res;

  always_comb begin
    a_sign = wide_i ? a_i[63] : a_i[31];
    b_sign = wide_i ? b_i[63] : b_i[31];
    a_exp = wide_i ? {1'b0, a_i[62:52]} : {4'b0, a_i[30:23]};
    b_exp = wide_i ? {1'b0, b_i[62:52]} : {4'b0, b_i[30:23]};
    a_sig = wide_i ? {a_exp != 12'd0, a_i[51:0]} : {a_exp != 12'd0, a_i[22:0], 29'd0};
    b_sig = wide_i ? {b_exp != 12'd0, b_i[51:0]} : {b_exp != 12'd0, b_i[22:0], 29'd0};
    a_eeff = (a_exp == 12'd0) ? 12'd1 : a_exp;
    b_eeff = (b_exp == 12'd0) ? 12'd1 : b_exp;
    emax = wide_i ? 12'd2047 : 12'd255;
    a_nan = (a_exp == emax) && (a_sig[51:0] != 52'd0);
    b_nan = (b_exp == emax) && (b_sig[51:0] != 52'd0);
    a_inf = (a_exp == emax) && (a_sig[51:0] == 52'd0);
    b_inf = (b_exp == emax) && (b_sig[51:0] == 52'd0);
    a_mag = wide_i ? a_i[62:0] : {32'd0, a_i[30:0]};
    b_mag = wide_i ? b_i[62:0] : {32'd0, b_i[30:0]};
    a_ge = a_mag >= b_mag;
    qnan = wide_i ? QNAN64 : QNAN32;
    a_in = wide_i ? a_i : (a_i & MASK32);
    b_in = wide_i ? b_i : (b_i & MASK32);
    special = a_nan || b_nan || a_inf || b_inf;
    if (a_nan || b_nan || (a_inf && b_inf && (a_sign != b_sign))) begin
      spec_res = qnan;
    end else if (a_inf) begin
      spec_res = a_in;
    end else begin
      spec_res = b_in;
    end
  end

  always_comb begin
    d = ea_q - eb_q;
    bw = {mb_q, 3'b000};
    lost = (56'd1 << d[5:0]) - 56'd1;
    if (d > 12'd55) begin
      shv = 56'd0;
      st = |mb_q;
    end else begin
      shv = bw >> d[5:0];
      st = |(bw & lost);
    end
    shv[0] = shv[0] | st;
    if (sub_q) begin
      sum = {1'b0, ma_q, 3'b000} - {1'b0, shv};
    end else begin
      sum = {1'b0, ma_q, 3'b000} + {1'b0, shv};
    end
  end

  always_comb begin
    mant = wide_q ? {1'b0, s_q[55:3]} : {30'd0, s_q[55:32]};
    g = wide_q ? s_q[2] : s_q[31];
    rst_bit = wide_q ? (|s_q[1:0]) : (|s_q[30:0]);
    up = g && (rst_bit || mant[0]);
    mr = mant + {53'd0, up};
    ovf = wide_q ? mr[53] : mr[24];
    er = e_q;
    if (ovf) begin
      mr = mr >> 1;
      er = e_q + 12'd1;
    end
    hidden = wide_q ? mr[52] : mr[23];
    ef = hidden ? er : 12'd0;
    if (wide_q) begin
      if (er >= 12'd2047) begin
        rnd_res = {sign_q, 11'h7FF, 52'd0};
      end else begin
        rnd_res = {sign_q, ef[10:0], mr[51:0]};
      end
    end else begin
      if (er >= 12'd255) begin
        rnd_res = {32'd0, sign_q, 8'hFF, 23'd0};
      end else begin
        rnd_res = {32'd0, sign_q, ef[7:0], mr[22:0]};
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: if (start_i) state_d = special ? F_DONE : F_ALIGN;
      F_ALIGN: state_d = F_NORM;
      F_NORM: begin
        if (!s_q[56] && !((s_q[55:48] == 8'd0) && (e_q > 12'd8))
            && (s_q[55] || (e_q <= 12'd1))) begin
          state_d = F_ROUND;
        end else if (s_q[56]) begin
          state_d = F_ROUND;
        end
      end
      F_ROUND: state_d = F_DONE;
      F_DONE: state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      F_IDLE: begin
        if (start_i) begin
          wide_q <= wide_i;
          result_q <= spec_res;
          sub_q <= a_sign ^ b_sign;
          if (a_ge) begin
            sa_q <= a_sign;
            ea_q <= a_eeff;
            ma_q <= a_sig;
            eb_q <= b_eeff;
            mb_q <= b_sig;
          end else begin
            sa_q <= b_sign;
            ea_q <= b_eeff;
            ma_q <= b_sig;
            eb_q <= a_eeff;
            mb_q <= a_sig;
          end
        end
      end
      F_ALIGN: begin
        s_q <= sum;
        e_q <= ea_q;
        sign_q <= (sub_q && (sum == 57'd0)) ? 1'b0 : sa_q;
      end
      F_NORM: begin
        if (s_q[56]) begin
          s_q <= {1'b0, s_q[56:2], s_q[1] | s_q[0]};
          e_q <= e_q + 12'd1;
        end else if ((s_q[55:48] == 8'd0) && (e_q > 12'd8)) begin
          s_q <= s_q << 8;
          e_q <= e_q - 12'd8;
        end else if (!s_q[55] && (e_q > 12'd1)) begin
          s_q <= s_q << 1;
          e_q <= e_q - 12'd1;
        end
      end
      F_ROUND: result_q <= rnd_res;
      default: begin
      end
    endcase
  end

  assign done_o = (state_q == F_DONE);
  assign result_o = result_q;

endmodule

[rtl/atomic_memory_op_unit.sv]
// Top level of the atomic memory operation unit.
// Each request reads its word or word pair, computes the new value, writes it back and
// returns the old value. One request is worked on at a time, and the next is taken while
// the previous result still waits in the output register. A 32-bit integer, bitwise,
// min/max or compare-exchange request goes through read, update and write; a 64-bit one
// writes its two words one after the other, since the store has one write port. A float
// add runs through the multi-cycle adder, which repeats its normalization step after
// cancellation as needed (a step removes up to eight leading zeros, and an exact zero sum
// steps the exponent all the way down). A float add with an infinite or NaN operand
// bypasses the adder's datapath. After reset the store is cleared one word a cycle, and
// in_stall_o stays high while the store is being cleared.
module atomic_memory_op_unit #(
  parameter int STORE_WORDS = amo_pkg::DEFAULT_STORE_WORDS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [3:0]  op_kind_i,
  input  logic        wide_i,
  input  logic [9:0]  word_index_i,
  input  logic [63:0] operand_i,
  input  logic [63:0] expected_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] old_value_o
);
  import amo_pkg::*;

  localparam int AW = $clog2(STORE_WORDS);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_FWAIT = 3'd3;
  localparam logic [2:0] S_WLO = 3'd4;
  localparam logic [2:0] S_WHI = 3'd5;
  localparam logic [2:0] S_RESP = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          out_valid_q, out_valid_d;
  logic [63:0]   old_value_q;

  amo_op_t       op_q;
  logic [AW-1:0] lo_q, hi_q;
  logic [63:0]   operand_q, expected_q, old_q, new_q;

  logic [IDX_W-1:0] idx_mod;
  logic [AW-1:0]    lo_a, hi_a;
  logic [AW:0]      hi_ext;
  logic             accept, finish, out_free, load_out, fadd_start, is_fadd;

  logic [31:0]   rd_a, rd_b;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic [63:0]   old_mem, alu_new, fadd_res;
  logic          fadd_done;
  logic [63:0]   in_mask;

  always_comb begin
    int step;
    idx_mod = word_index_i;
    for (int k = IDX_W - 1; k >= 0; k--) begin
      step = STORE_WORDS << k;
      if (step <= IDX_MAX && 32'(idx_mod) >= step) begin
        idx_mod = idx_mod - IDX_W'(step);
      end
    end
    lo_a = AW'(idx_mod);
    if (wide_i) begin
      lo_a[0] = 1'b0;
    end
    hi_ext = {1'b0, lo_a} + {{AW{1'b0}}, 1'b1};
    hi_a = (hi_ext >= (AW + 1)'(STORE_WORDS)) ? '0 : hi_ext[AW-1:0];
  end

  assign accept = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign in_mask = wide_i ? '1 : MASK32;
  assign out_free = !out_valid_q || !out_stall_i;
  assign old_mem = op_q.wide ? {rd_b, rd_a} : {32'd0, rd_a};
  assign is_fadd = (op_q.cmd == CMD_RMW) && (op_q.kind == K_FADD);
  assign fadd_start = (state_q == S_EXEC) && is_fadd;
  assign finish = ((state_q == S_WLO) && !op_q.wide) || (state_q == S_WHI)
                  || (state_q == S_RESP);
  assign load_out = finish && out_free;

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    wr_en = 1'b0;
    wr_addr = lo_q;
    wr_data = new_q[31:0];
    unique case (state_q)
      S_CLEAR: begin
        wr_en = 1'b1;
        wr_addr = clr_q;
        wr_data = 32'd0;
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(STORE_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: if (accept) state_d = S_EXEC;
      S_EXEC: state_d = is_fadd ? S_FWAIT : S_WLO;
      S_FWAIT: if (fadd_done) state_d = S_WLO;
      S_WLO: begin
        wr_en = 1'b1;
        if (op_q.wide) begin
          state_d = S_WHI;
        end else begin
          state_d = out_free ? S_IDLE : S_RESP;
        end
      end
      S_WHI: begin
        wr_en = 1'b1;
        wr_addr = hi_q;
        wr_data = new_q[63:32];
        state_d = out_free ? S_IDLE : S_RESP;
      end
      S_RESP: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= '{cmd: cmd_i, kind: op_kind_e'(op_kind_i), wide: wide_i};
      lo_q <= lo_a;
      hi_q <= hi_a;
      operand_q <= operand_i & in_mask;
      expected_q <= expected_value_i & in_mask;
    end
    if (state_q == S_EXEC) begin
      old_q <= old_mem;
      new_q <= alu_new;
    end
    if ((state_q == S_FWAIT) && fadd_done) begin
      new_q <= fadd_res;
    end
    if (load_out) begin
      old_value_q <= old_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign old_value_o = old_value_q;

  amo_store #(
    .WORDS(STORE_WORDS),
    .AW(AW)
  ) u_store (
    .clk_i(clk_i),
    .rd_en_i(accept),
    .rd_addr_a_i(lo_a),
    .rd_addr_b_i(hi_a),
    .rd_data_a_o(rd_a),
    .rd_data_b_o(rd_b),
    .wr_en_i(wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  amo_alu u_alu (
    .op_i(op_q),
    .old_i(old_mem),
    .operand_i(operand_q),
    .expected_i(expected_q),
    .new_o(alu_new)
  );

  amo_fadd u_fadd (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(fadd_start),
    .wide_i(op_q.wide),
    .a_i(old_mem),
    .b_i(operand_q),
    .done_o(fadd_done),
    .result_o(fadd_res)
  );

endmodule

[rtl/amo_checker.sv]
// Port-level checks of the atomic memory operation unit and their binding.
module amo_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] old_value_o
);

  logic [2:0] cnt_q;
  logic       in_acc, out_acc;

  assign in_acc = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else begin
      cnt_q <= cnt_q + {2'd0, in_acc} - {2'd0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(old_value_o))
    else $error("Stalled result beat changed.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("Input taken while a request was in progress.");

  a_outstanding_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd2)
    else $error("More than two requests outstanding.");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != 3'd0)
    else $error("Result beat without a pending request.");

endmodule

bind atomic_memory_op_unit amo_checker u_amo_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_valid_i(in_valid_i),
  .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .old_value_o(old_value_o)
);

[verif/atomic_result_checker.sv]
// Checker that predicts and compares the old values returned by the atomic memory unit.
`timescale 1ns / 1ps

module atomic_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        cmd_i,
  input  logic [3:0]  op_kind_i,
  input  logic        wide_i,
  input  logic [9:0]  word_index_i,
  input  logic [63:0] operand_i,
  input  logic [63:0] expected_value_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [63:0] old_value_i,
  output int          fail_count_o,
  output int          pending_o
);
  import amo_pkg::*;

  localparam int WORDS = DEFAULT_STORE_WORDS;

  logic [31:0] shadow_words [WORDS];
  logic [63:0] expected_olds [$];
  int          fails;

  function automatic bit is_nan(logic [63:0] x, bit wide);
    logic [63:0] sign;
    logic [63:0] inf;
    logic [63:0] mask;
    sign = wide ? SIGN64 : SIGN32;
    inf  = wide ? INF64 : INF32;
    mask = wide ? ~64'd0 : MASK32;
    return (x & ~sign & mask) > inf;
  endfunction

  function automatic logic [63:0] order_key(logic [63:0] x, bit wide);
    logic [63:0] sign;
    logic [63:0] mask;
    sign = wide ? SIGN64 : SIGN32;
    mask = wide ? ~64'd0 : MASK32;
    return (x & sign) != 0 ? (~x & mask) : (x | sign);
  endfunction

  function automatic logic [63:0] single_to_double(logic [31:0] f);
    logic        s;
    logic [7:0]  e;
    logic [22:0] m;
    logic [63:0] shifted;
    int          p;
    s = f[31];
    e = f[30:23];
    m = f[22:0];
    if (e == 8'hFF) return {s, 11'h7FF, m, 29'b0};
    if (e != 0) return {s, 11'(int'(e) + 896), m, 29'b0};
    if (m == 0) return {s, 63'b0};
    p = 22;
    while (!m[p]) p--;
    shifted = {41'b0, m} << (52 - p);
    return {s, 11'(p - 149 + 1023), shifted[51:0]};
  endfunction

  function automatic logic [31:0] double_to_single(logic [63:0] d);
    logic        s;
    logic [10:0] e;
    logic [63:0] sig;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] val;
    int          ex;
    int          sh;
    s = d[63];
    e = d[62:52];
    if (e == 11'h7FF) return {s, 8'hFF, 23'b0};
    if (e == 0) return {s, 31'b0};
    ex = int'(e) - 896;
    sig = {11'b0, 1'b1, d[51:0]};
    sh = (ex >= 1) ? 29 : 29 + 1 - ex;
    if (sh > 60) sh = 60;
    q = sig >> sh;
    rem = sig & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 1;
    val = (64'((ex >= 1) ? ex - 1 : 0) << 23) + q;
    if (val >= 64'h7F80_0000) val = 64'h7F80_0000;
    return {s, val[30:0]};
  endfunction

  function automatic logic [63:0] float_sum(logic [63:0] a, logic [63:0] b, bit wide);
    real         x;
    real         y;
    logic [63:0] bits;
    if (is_nan(a, wide) || is_nan(b, wide)) return wide ? QNAN64 : QNAN32;
    if (wide) begin
      x = $bitstoreal(a);
      y = $bitstoreal(b);
    end else begin
      x = $bitstoreal(single_to_double(a[31:0]));
      y = $bitstoreal(single_to_double(b[31:0]));
    end
    bits = $realtobits(x + y);
    if (is_nan(bits, 1'b1)) return wide ? QNAN64 : QNAN32;
    return wide ? bits : {32'b0, double_to_single(bits)};
  endfunction

  function automatic logic [63:0] float_pick(logic [63:0] a, logic [63:0] b, op_kind_e kind,
                                             bit wide);
    bit          an;
    bit          bn;
    bit          want_max;
    logic [63:0] ka;
    logic [63:0] kb;
    an = is_nan(a, wide);
    bn = is_nan(b, wide);
    want_max = (kind == K_FMAXIMUM || kind == K_FMAXNUM);
    if (kind == K_FMINIMUM || kind == K_FMAXIMUM) begin
      if (an || bn) return wide ? QNAN64 : QNAN32;
    end else begin
      if (an && bn) return wide ? QNAN64 : QNAN32;
      if (an) return b;
      if (bn) return a;
    end
    ka = order_key(a, wide);
    kb = order_key(b, wide);
    if (want_max) return ka > kb ? a : b;
    return ka < kb ? a : b;
  endfunction

  function automatic logic [63:0] updated_value(logic [63:0] old, logic [63:0] op,
                                                op_kind_e kind, bit wide);
    logic [63:0] sign;
    sign = wide ? SIGN64 : SIGN32;
    case (kind)
      K_XCHG, K_XCHGF: return op;
      K_ADD:  return old + op;
      K_FADD: return float_sum(old, op, wide);
      K_SUB:  return old - op;
      K_AND:  return old & op;
      K_OR:   return old | op;
      K_XOR:  return old ^ op;
      K_SMIN: return (old ^ sign) < (op ^ sign) ? old : op;
      K_SMAX: return (old ^ sign) > (op ^ sign) ? old : op;
      K_UMIN: return old < op ? old : op;
      K_UMAX: return old > op ? old : op;
      default: return float_pick(old, op, kind, wide);
    endcase
  endfunction

  task automatic apply_request();
    logic [63:0] mask;
    logic [63:0] op;
    logic [63:0] cmp;
    logic [63:0] old;
    logic [63:0] nv;
    int          lo;
    int          hi;
    mask = wide_i ? ~64'd0 : MASK32;
    op = operand_i & mask;
    cmp = expected_value_i & mask;
    lo = int'(word_index_i) % WORDS;
    hi = 0;
    if (wide_i) begin
      lo = lo & ~1;
      hi = (lo + 1 >= WORDS) ? 0 : lo + 1;
      old = {shadow_words[hi], shadow_words[lo]};
    end else begin
      old = {32'b0, shadow_words[lo]};
    end
    if (cmd_i == CMD_CAS) nv = (old == cmp) ? op : old;
    else nv = updated_value(old, op, op_kind_e'(op_kind_i), wide_i) & mask;
    shadow_words[lo] = nv[31:0];
    if (wide_i) shadow_words[hi] = nv[63:32];
    expected_olds.push_back(old);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [63:0] want;
    if (!rst_ni) begin
      for (int i = 0; i < WORDS; i++) shadow_words[i] = '0;
      expected_olds.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_olds.size() == 0) begin
          $error("unexpected result beat: old_value %h", old_value_i);
          fails++;
        end else begin
          want = expected_olds.pop_front();
          if (old_value_i !== want) begin
            $error("old_value mismatch: expected %h, actual %h", want, old_value_i);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) apply_request();
      fail_count_o <= fails;
      pending_o <= expected_olds.size();
    end
  end

endmodule

[verif/atomic_memory_op_unit_test.sv]
// Testbench top that drives the atomic memory unit and reports the verdict.
`timescale 1ns / 1ps

module atomic_memory_op_unit_test;
  import amo_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 320;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        cmd_i = 1'b0;
  logic [3:0]  op_kind_i = '0;
  logic        wide_i = 1'b0;
  logic [9:0]  word_index_i = '0;
  logic [63:0] operand_i = '0;
  logic [63:0] expected_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] old_value_o;

  int          fail_count;
  int          pending;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_req = 0;
  logic [63:0] last_operand = '0;

  atomic_memory_op_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i, .op_kind_i, .wide_i,
    .word_index_i, .operand_i, .expected_value_i, .out_valid_o, .out_stall_i, .old_value_o
  );

  atomic_result_checker checker_inst (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .cmd_i, .op_kind_i, .wide_i,
    .word_index_i, .operand_i, .expected_value_i, .out_valid_i(out_valid_o), .out_stall_i,
    .old_value_i(old_value_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    int hold_left;
    int hold_seen;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left = 0;
      hold_seen = 0;
    end else begin
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else idle++;
    end
    $display("tb: failure");
    $finish;
  end

  task automatic send_beat(logic cmd, logic [3:0] kind, logic wide, logic [9:0] idx,
                           logic [63:0] op, logic [63:0] cmp);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    op_kind_i <= kind;
    wide_i <= wide;
    word_index_i <= idx;
    operand_i <= op;
    expected_value_i <= cmp;
    last_operand = op;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [63:0] pick_value();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(9))
      0, 1, 2: return r;
      3: return {r[63:32], 29'b0, 3'($urandom_range(7))};
      4: return ~64'($urandom_range(3));
      5, 6: begin
        case ($urandom_range(11))
          0: return {r[63:32], 32'h0000_0000};
          1: return {r[63:32], 32'h8000_0000};
          2: return {r[63:32], 32'h7F80_0000};
          3: return {r[63:32], 32'hFF80_0000};
          4: return {r[63:32], 32'h7FC0_0000};
          5: return {r[63:32], 32'h7F80_0001};
          6: return {r[63:32], 32'h0000_0001};
          7: return {r[63:32], 32'h807F_FFFF};
          8: return {r[63:32], 32'h3F80_0000};
          9: return {r[63:32], 32'hBF80_0000};
          10: return {r[63:32], 32'h7F7F_FFFF};
          default: return {r[63:32], 1'b0, 8'h7F, r[22:0]};
        endcase
      end
      default: begin
        case ($urandom_range(11))
          0: return 64'h0;
          1: return SIGN64;
          2: return INF64;
          3: return INF64 | SIGN64;
          4: return QNAN64;
          5: return 64'h7FF0_0000_0000_0001;
          6: return 64'h1;
          7: return 64'h800F_FFFF_FFFF_FFFF;
          8: return 64'h3FF0_0000_0000_0000;
          9: return 64'hBFF0_0000_0000_0000;
          10: return 64'h7FEF_FFFF_FFFF_FFFF;
          default: return {2'b00, 10'h3FF, r[51:0]};
        endcase
      end
    endcase
  endfunction

  task automatic send_random();
    logic [9:0]  idx;
    logic [63:0] cmp;
    if ($urandom_range(99) < 70) begin
      idx = $urandom_range(1) ? 10'($urandom_range(7)) : 10'(1016 + $urandom_range(7));
    end else begin
      idx = 10'($urandom_range(IDX_MAX));
    end
    case ($urandom_range(3))
      0: cmp = '0;
      1: cmp = last_operand;
      default: cmp = pick_value();
    endcase
    send_beat(($urandom_range(99) < 25) ? CMD_CAS : CMD_RMW, 4'($urandom_range(15)),
              1'($urandom_range(1)), idx, pick_value(), cmp);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(CMD_CAS, K_XCHG, 1'b1, 10'd0, ~64'd0, 64'd0);
    send_beat(CMD_CAS, K_XCHG, 1'b1, 10'd1, 64'd5, 64'd0);
    send_beat(CMD_RMW, K_XCHG, 1'b0, 10'd1, 64'd0, 64'd0);
    send_beat(CMD_RMW, K_ADD, 1'b0, 10'd2, ~64'd0, 64'd0);
    send_beat(CMD_RMW, K_ADD, 1'b0, 10'd2, 64'd1, 64'd0);
    send_beat(CMD_RMW, K_SUB, 1'b1, 10'd4, 64'd1, 64'd0);
    send_beat(CMD_RMW, K_AND, 1'b1, 10'd5, 64'hF0F0_F0F0_0F0F_0F0F, 64'd0);
    send_beat(CMD_RMW, K_OR, 1'b1, 10'd4, 64'h1234_5678_9ABC_DEF0, 64'd0);
    send_beat(CMD_RMW, K_XOR, 1'b1, 10'd4, ~64'd0, 64'd0);
    send_beat(CMD_RMW, K_SMIN, 1'b0, 10'd6, 64'h8000_0000, 64'd0);
    send_beat(CMD_RMW, K_SMAX, 1'b0, 10'd6, 64'h7FFF_FFFF, 64'd0);
    send_beat(CMD_RMW, K_SMIN, 1'b0, 10'd6, 64'h7FFF_FFFF, 64'd0);
    send_beat(CMD_RMW, K_UMIN, 1'b0, 10'd6, 64'd0, 64'd0);
    send_beat(CMD_RMW, K_UMAX, 1'b1, 10'd6, ~64'd0, 64'd0);
    send_beat(CMD_RMW, K_FADD, 1'b0, 10'd8, 64'h3F80_0000, 64'd0);
    send_beat(CMD_RMW, K_FADD, 1'b0, 10'd8, 64'hBF7F_FFFF, 64'd0);
    send_beat(CMD_RMW, K_FADD, 1'b0, 10'd9, 64'h7F80_0000, 64'd0);
    send_beat(CMD_RMW, K_FADD, 1'b0, 10'd9, 64'hFF80_0000, 64'd0);
    send_beat(CMD_RMW, K_FADD, 1'b1, 10'd10, 64'h3FF0_0000_0000_0000, 64'd0);
    send_beat(CMD_RMW, K_FMINIMUM, 1'b0, 10'd12, 64'h8000_0000, 64'd0);
    send_beat(CMD_RMW, K_FMAXIMUM, 1'b0, 10'd12, 64'h7FC0_0000, 64'd0);
    send_beat(CMD_RMW, K_FMINNUM, 1'b0, 10'd12, 64'h3F80_0000, 64'd0);
    send_beat(CMD_RMW, K_FMAXNUM, 1'b0, 10'd12, 64'h7F80_0001, 64'd0);
    send_beat(CMD_RMW, K_XCHGF, 1'b1, 10'd1023, 64'hFFF0_0000_0000_0001, 64'd0);
    send_beat(CMD_CAS, K_FMAXNUM, 1'b0, 10'd1022, 64'hDEAD_BEEF, 64'h0000_0001);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; hold_req++; end
        1: begin send_idle_pct = 87; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 87; end
        3: begin send_idle_pct = 16; recv_stall_pct = 16; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) send_random();
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/amo_pkg.sv
rtl/amo_store.sv
rtl/amo_alu.sv
rtl/amo_fadd.sv
rtl/atomic_memory_op_unit.sv
rtl/amo_checker.sv
verif/atomic_result_checker.sv
verif/atomic_memory_op_unit_test.sv
